// ===== hw/rtl/wfs_pkg.sv =====
// Package for the weighted field selector: sizes, register map, state codes
// and the command and status bundles between controller and datapath.
// Depends on nothing; every other file of the block uses it.
package wfs_pkg;

	localparam int MAX_FIELDS = 64;
	localparam int HIT_BITS   = 24;

	localparam int IDX_W   = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int CNT_W   = $clog2(MAX_FIELDS + 1);
	localparam int RND_W   = 31;
	localparam int CTR_W   = (CNT_W > 6) ? CNT_W : 6;
	localparam int TOTAL_W = HIT_BITS + CNT_W;
	localparam int NUM_W   = 7;
	localparam int FIELD_W = 6;
	localparam int ADDR_W  = 3;

	localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

	localparam logic CMD_SELECT = 1'b0;
	localparam logic CMD_REWARD = 1'b1;

	localparam logic REG_NUM_FIELDS = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MOD,
		ST_WALK,
		ST_FINISH,
		ST_RW_RD,
		ST_RW_WR
	} state_t;

	typedef struct packed {
		logic load_in;
		logic clr;
		logic issue;
		logic addr_field;
		logic sum_en;
		logic mod_en;
		logic walk_en;
		logic wr_en;
	} dp_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic in_range;
		logic sum_done;
		logic mod_done;
		logic walk_done;
	} dp_status_t;

endpackage

// ===== hw/rtl/wfs_ctrl.sv =====
// Controller state machine of the weighted field selector.
// Depends on wfs_pkg; drives the datapath through dp_cmd_t and reads dp_status_t.
module wfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                cmd,
	input  logic                out_valid,
	input  logic                out_stall,
	input  wfs_pkg::dp_status_t status,
	output wfs_pkg::dp_cmd_t    dp_cmd,
	output logic                in_stall,
	output logic                out_load
);

	wfs_pkg::state_t state_q;
	wfs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wfs_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (cmd == wfs_pkg::CMD_SELECT) begin
						state_d = status.n_zero ? wfs_pkg::ST_FINISH : wfs_pkg::ST_SUM;
					end else if (status.in_range) begin
						state_d = wfs_pkg::ST_RW_RD;
					end
				end
			end
			wfs_pkg::ST_SUM: begin
				if (status.sum_done) state_d = wfs_pkg::ST_MOD;
			end
			wfs_pkg::ST_MOD: begin
				if (status.mod_done) state_d = wfs_pkg::ST_WALK;
			end
			wfs_pkg::ST_WALK: begin
				if (status.walk_done) state_d = wfs_pkg::ST_FINISH;
			end
			wfs_pkg::ST_FINISH: begin
				if (!out_valid || !out_stall) state_d = wfs_pkg::ST_IDLE;
			end
			wfs_pkg::ST_RW_RD: state_d = wfs_pkg::ST_RW_WR;
			wfs_pkg::ST_RW_WR: state_d = wfs_pkg::ST_IDLE;
			default: state_d = wfs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		dp_cmd   = '0;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			wfs_pkg::ST_IDLE: begin
				in_stall       = 1'b0;
				dp_cmd.load_in = in_valid;
			end
			wfs_pkg::ST_SUM: begin
				dp_cmd.issue  = 1'b1;
				dp_cmd.sum_en = 1'b1;
				dp_cmd.clr    = status.sum_done;
			end
			wfs_pkg::ST_MOD: begin
				dp_cmd.mod_en = 1'b1;
				dp_cmd.clr    = status.mod_done;
			end
			wfs_pkg::ST_WALK: begin
				dp_cmd.issue   = 1'b1;
				dp_cmd.walk_en = 1'b1;
			end
			wfs_pkg::ST_FINISH: begin
				out_load = !out_valid || !out_stall;
			end
			wfs_pkg::ST_RW_RD: begin
				dp_cmd.issue      = 1'b1;
				dp_cmd.addr_field = 1'b1;
			end
			wfs_pkg::ST_RW_WR: begin
				dp_cmd.wr_en = 1'b1;
			end
			default: begin
				dp_cmd = '0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/wfs_datapath.sv =====
// Datapath of the weighted field selector: hit counter memory with valid bits,
// weight accumulator, restoring modulo unit and cumulative walk.
// Depends on wfs_pkg; controlled by wfs_ctrl through dp_cmd_t.
module wfs_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wfs_pkg::dp_cmd_t               dp_cmd,
	input  logic [wfs_pkg::NUM_W-1:0]      num_fields,
	input  logic [wfs_pkg::RND_W-1:0]      random_value,
	input  logic [wfs_pkg::FIELD_W-1:0]    field_index,
	output wfs_pkg::dp_status_t            status,
	output logic [wfs_pkg::FIELD_W-1:0]    result
);

	logic [wfs_pkg::HIT_BITS-1:0] hit_mem [wfs_pkg::MAX_FIELDS];
	logic [wfs_pkg::MAX_FIELDS-1:0] vld_q;

	logic [wfs_pkg::CNT_W-1:0]    act;
	logic [wfs_pkg::CTR_W-1:0]    cnt_q;
	logic [wfs_pkg::IDX_W-1:0]    fidx_q;
	logic [wfs_pkg::RND_W-1:0]    rnd_q;
	logic [wfs_pkg::TOTAL_W-1:0]  sum_q;
	logic [wfs_pkg::TOTAL_W-1:0]  rem_q;
	logic [wfs_pkg::TOTAL_W-1:0]  wacc_q;
	logic                         found_q;
	logic [wfs_pkg::IDX_W-1:0]    chosen_q;

	logic                         pend_s1;
	logic [wfs_pkg::IDX_W-1:0]    idx_s1;
	logic [wfs_pkg::HIT_BITS-1:0] rd_data_s1;
	logic                         rd_vld_s1;

	logic [wfs_pkg::IDX_W-1:0]    rd_addr;
	logic                         issue_ok;
	logic [wfs_pkg::TOTAL_W-1:0]  weight;
	logic [wfs_pkg::TOTAL_W-1:0]  wacc_next;
	logic [wfs_pkg::TOTAL_W:0]    mod_shift;
	logic [wfs_pkg::TOTAL_W:0]    mod_diff;
	logic [wfs_pkg::HIT_BITS-1:0] wr_data;
	logic [wfs_pkg::IDX_W-1:0]    res_idx;

	always_comb begin
		if (32'(num_fields) > 32'(wfs_pkg::MAX_FIELDS)) begin
			act = wfs_pkg::CNT_W'(wfs_pkg::MAX_FIELDS);
		end else begin
			act = wfs_pkg::CNT_W'(num_fields);
		end
	end

	assign rd_addr   = dp_cmd.addr_field ? fidx_q : cnt_q[wfs_pkg::IDX_W-1:0];
	assign issue_ok  = dp_cmd.issue
		&& (dp_cmd.addr_field || (32'(cnt_q) < 32'(act) && !(dp_cmd.walk_en && found_q)));
	assign weight    = wfs_pkg::TOTAL_W'(rd_vld_s1 ? rd_data_s1 : '0) + wfs_pkg::TOTAL_W'(1);
	assign wacc_next = wacc_q + weight;
	assign mod_shift = {rem_q, rnd_q[wfs_pkg::RND_W-1]};
	assign mod_diff  = mod_shift - {1'b0, sum_q};

	always_comb begin
		if (!rd_vld_s1) begin
			wr_data = wfs_pkg::HIT_BITS'(1);
		end else if (rd_data_s1 == wfs_pkg::HIT_MAX) begin
			wr_data = rd_data_s1;
		end else begin
			wr_data = rd_data_s1 + wfs_pkg::HIT_BITS'(1);
		end
	end

	// Counter memory: one read port with registered data, one write port.
	always_ff @(posedge clk) begin
		if (dp_cmd.wr_en) hit_mem[fidx_q] <= wr_data;
		rd_data_s1 <= hit_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			pend_s1   <= 1'b0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
		end else begin
			if (dp_cmd.wr_en) vld_q[fidx_q] <= 1'b1;
			if (dp_cmd.load_in || dp_cmd.clr) begin
				pend_s1 <= 1'b0;
				cnt_q   <= '0;
				found_q <= dp_cmd.load_in;
			end else begin
				pend_s1 <= issue_ok;
				if ((issue_ok && !dp_cmd.addr_field) || dp_cmd.mod_en) begin
					cnt_q <= cnt_q + wfs_pkg::CTR_W'(1);
				end
				if (dp_cmd.walk_en && pend_s1 && !found_q && (rem_q < wacc_next)) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_s1 <= vld_q[rd_addr];
		idx_s1    <= rd_addr;
		if (dp_cmd.load_in) begin
			fidx_q   <= wfs_pkg::IDX_W'(field_index);
			rnd_q    <= random_value;
			sum_q    <= '0;
			rem_q    <= '0;
			chosen_q <= '0;
		end else begin
			if (dp_cmd.sum_en && pend_s1) sum_q <= sum_q + weight;
			if (dp_cmd.mod_en && !status.mod_done) begin
				rnd_q <= rnd_q << 1;
				if (!mod_diff[wfs_pkg::TOTAL_W]) begin
					rem_q <= mod_diff[wfs_pkg::TOTAL_W-1:0];
				end else begin
					rem_q <= mod_shift[wfs_pkg::TOTAL_W-1:0];
				end
			end
			if (dp_cmd.walk_en && pend_s1 && !found_q && (rem_q < wacc_next)) begin
				chosen_q <= idx_s1;
			end
		end
		if (dp_cmd.clr) begin
			wacc_q <= '0;
		end else if (dp_cmd.walk_en && pend_s1) begin
			wacc_q <= wacc_next;
		end
	end

	// Fallback to the last active field if the walk runs out; it does not in practice.
	assign res_idx = found_q ? chosen_q : wfs_pkg::IDX_W'(act - wfs_pkg::CNT_W'(1));
	assign result  = wfs_pkg::FIELD_W'(res_idx);

	assign status.n_zero    = (act == '0);
	assign status.in_range  = (32'(field_index) < 32'(act));
	assign status.sum_done  = (32'(cnt_q) >= 32'(act)) && !pend_s1;
	assign status.mod_done  = (32'(cnt_q) == 32'(wfs_pkg::RND_W));
	assign status.walk_done = found_q || ((32'(cnt_q) >= 32'(act)) && !pend_s1);

endmodule

// ===== hw/rtl/weighted_field_selector_top.sv =====
// Weighted field selector: roulette-wheel pick over saturating hit counters.
// A select beat's result is registered after a sum pass and a walk over at most N active
// fields via the counter memory's single read port, with 31 restoring modulo steps between;
// a stalled result register holds it. A zero-field select skips both passes, a reward beat
// reads and writes one counter; beats are taken one at a time, only in the idle state.
// Reset (arst_n, asynchronous, active low) clears all hit counters at once through
// per-entry valid bits, sets num_fields to 0 and leaves no result pending.
module weighted_field_selector_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wfs_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	// Input channel.
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [wfs_pkg::RND_W-1:0]       random_value,
	input  logic [wfs_pkg::FIELD_W-1:0]     field_index,
	// Result channel.
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [wfs_pkg::FIELD_W-1:0]     chosen_field
);

	logic [wfs_pkg::NUM_W-1:0]   num_fields_q;
	logic                        out_valid_q;
	logic [wfs_pkg::FIELD_W-1:0] chosen_field_q;

	wfs_pkg::dp_cmd_t            dp_cmd;
	wfs_pkg::dp_status_t         status;
	logic                        out_load;
	logic [wfs_pkg::FIELD_W-1:0] result;

	// The register index is the word address; the byte offset bits are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == wfs_pkg::REG_NUM_FIELDS)
		? 32'(num_fields_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_fields_q <= '0;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == wfs_pkg::REG_NUM_FIELDS) begin
			num_fields_q <= pwdata[wfs_pkg::NUM_W-1:0];
		end
	end

	wfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.out_valid (out_valid_q),
		.out_stall (out_stall),
		.status    (status),
		.dp_cmd    (dp_cmd),
		.in_stall  (in_stall),
		.out_load  (out_load)
	);

	wfs_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.num_fields   (num_fields_q),
		.random_value (random_value),
		.field_index  (field_index),
		.status       (status),
		.result       (result)
	);

	// The output register holds a finished result while the next beat is already
	// accepted and worked on; a second result waits in the controller until it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) chosen_field_q <= result;
	end

	assign out_valid    = out_valid_q;
	assign chosen_field = chosen_field_q;

endmodule
